/* hw/rtl/ftc_pkg.sv */
// shared constants and types for the flow tuple classifier
// no dependencies
package ftc_pkg;

	localparam int FLOW_ENTRIES_DEF = 64;
	localparam int ADDR_W           = 16;
	localparam int EP_W             = 8;
	localparam int KEY_W            = 2 * ADDR_W + 2 * EP_W;
	localparam int FLOW_W           = 7;
	localparam int PKT_CNT_W        = 32;

	typedef logic [KEY_W-1:0] ftc_key_t;

	typedef struct packed {
		logic hit;
		logic new_flow;
		logic full;
	} ftc_match_t;

endpackage

/* hw/rtl/flow_tuple_classifier_core.sv */
// an item passes through the input, lookup and result registers in that order
// throughput: one item per cycle while no result is stalled; key compare runs across all entries in parallel
// packet counters live in a one-read one-write memory with write-to-read bypass
// whole pipeline holds while a result is stalled
// reset clears valid bits, entry count and pipeline valids; counters need no clear
module flow_tuple_classifier_core
	import ftc_pkg::*;
#(
	parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pkt_valid,
	output logic                 pkt_stall,
	input  logic [ADDR_W-1:0]    src_address,
	input  logic [ADDR_W-1:0]    dst_address,
	input  logic [EP_W-1:0]      src_endpoint,
	input  logic [EP_W-1:0]      dst_endpoint,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [FLOW_W-1:0]    flow_number,
	output logic [PKT_CNT_W-1:0] packet_number,
	output logic                 is_new_flow,
	output logic                 table_full
);

	localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
	localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);

	logic                 adv;
	logic                 valid_s1;
	ftc_key_t             key_s1;
	ftc_match_t           match_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 valid_s2;
	ftc_match_t           match_s2;
	logic [IDX_W-1:0]     idx_s2;
	logic [PKT_CNT_W-1:0] cnt_rd_s2;
	logic [PKT_CNT_W-1:0] cnt_next;
	logic                 cnt_wr;
	logic [PKT_CNT_W-1:0] cnt_mem [FLOW_ENTRIES];
	logic                 valid_q;
	logic [FLOW_W-1:0]    flow_number_q;
	logic [PKT_CNT_W-1:0] packet_number_q;
	logic                 is_new_flow_q;
	logic                 table_full_q;

	assign adv       = !(valid_q && res_stall);
	assign pkt_stall = !adv;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pkt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			key_s1 <= {src_address, dst_address, src_endpoint, dst_endpoint};
		end
	end

	ftc_match #(
		.FLOW_ENTRIES (FLOW_ENTRIES),
		.IDX_W        (IDX_W),
		.CNT_W        (CNT_W)
	) u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.lookup_en (adv && valid_s1),
		.key       (key_s1),
		.match     (match_s1),
		.idx       (idx_s1)
	);

	// lookup stage and counter memory
	assign cnt_next = match_s2.hit ? (cnt_rd_s2 + PKT_CNT_W'(1)) : '0;
	assign cnt_wr   = adv && valid_s2 && !match_s2.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			match_s2 <= match_s1;
			idx_s2   <= idx_s1;
			if (cnt_wr && (idx_s2 == idx_s1)) begin
				cnt_rd_s2 <= cnt_next;
			end else begin
				cnt_rd_s2 <= cnt_mem[idx_s1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_wr) begin
			cnt_mem[idx_s2] <= cnt_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flow_number_q   <= match_s2.full ? '0 : (FLOW_W'(idx_s2) + FLOW_W'(1));
			packet_number_q <= cnt_next;
			is_new_flow_q   <= match_s2.new_flow;
			table_full_q    <= match_s2.full;
		end
	end

	assign res_valid     = valid_q;
	assign flow_number   = flow_number_q;
	assign packet_number = packet_number_q;
	assign is_new_flow   = is_new_flow_q;
	assign table_full    = table_full_q;

	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $onehot({match_s2.hit, match_s2.new_flow, match_s2.full}))
		else $error("lookup outcome not exclusive");

	a_new_flow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && is_new_flow_q |-> packet_number_q == '0 && !table_full_q)
		else $error("new flow result with nonzero count");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> valid_s2 == $past(valid_s2) && valid_s1 == $past(valid_s1))
		else $error("pipeline moved while result stalled");

endmodule

/* hw/rtl/ftc_match.sv */
// exact-match key table with valid bits and in-order entry allocation
// depends on ftc_pkg
module ftc_match
	import ftc_pkg::*;
#(
	parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF,
	parameter int IDX_W        = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1,
	parameter int CNT_W        = $clog2(FLOW_ENTRIES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             lookup_en,
	input  ftc_key_t         key,
	output ftc_match_t       match,
	output logic [IDX_W-1:0] idx
);

	logic [FLOW_ENTRIES-1:0] entry_valid_q;
	ftc_key_t                entry_key_q [FLOW_ENTRIES];
	logic [CNT_W-1:0]        used_q;
	logic [FLOW_ENTRIES-1:0] hit_vec;
	logic [IDX_W-1:0]        hit_idx;
	logic                    full;
	logic                    alloc;

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < FLOW_ENTRIES; i++) begin
			hit_vec[i] = entry_valid_q[i] && (entry_key_q[i] == key);
			if (hit_vec[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
	end

	assign full           = (used_q == CNT_W'(FLOW_ENTRIES));
	assign match.hit      = |hit_vec;
	assign match.full     = !match.hit && full;
	assign match.new_flow = !match.hit && !full;
	assign idx            = match.hit ? hit_idx : used_q[IDX_W-1:0];
	assign alloc          = lookup_en && match.new_flow;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			used_q        <= '0;
		end else if (alloc) begin
			entry_valid_q[used_q[IDX_W-1:0]] <= 1'b1;
			used_q                            <= used_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (alloc) begin
			entry_key_q[used_q[IDX_W-1:0]] <= key;
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(FLOW_ENTRIES))
		else $error("entry count beyond table size");

	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		alloc |=> used_q == $past(used_q) + CNT_W'(1))
		else $error("allocation did not advance entry count");

endmodule

/* tb/flow_tuple_classifier_checker.sv */
// checker for the flow tuple classifier: tracks the flow table, predicts each result and compares
// depends on ftc_pkg for widths and the key type
module flow_tuple_classifier_checker
	import ftc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pkt_valid,
	input  logic                 pkt_stall,
	input  logic [ADDR_W-1:0]    src_address,
	input  logic [ADDR_W-1:0]    dst_address,
	input  logic [EP_W-1:0]      src_endpoint,
	input  logic [EP_W-1:0]      dst_endpoint,
	input  logic                 res_valid,
	input  logic                 res_stall,
	input  logic [FLOW_W-1:0]    flow_number,
	input  logic [PKT_CNT_W-1:0] packet_number,
	input  logic                 is_new_flow,
	input  logic                 table_full,
	output int                   mismatches,
	output int                   owed,
	output int                   new_flows,
	output int                   hits,
	output int                   full_misses
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [FLOW_W-1:0]    flow;
		logic [PKT_CNT_W-1:0] pkts;
		logic                 opened;
		logic                 full;
	} flow_verdict_t;

	logic                 flow_live [FLOW_ENTRIES_DEF];
	ftc_key_t             flow_key  [FLOW_ENTRIES_DEF];
	logic [PKT_CNT_W-1:0] flow_pkts [FLOW_ENTRIES_DEF];
	int                   flows_in_use;
	flow_verdict_t        owed_verdicts [$];
	flow_verdict_t        want;
	flow_verdict_t        seen;

	function automatic flow_verdict_t classify_tuple(input ftc_key_t k);
		flow_verdict_t v;
		v = '0;
		for (int i = 0; i < FLOW_ENTRIES_DEF; i++) begin
			if (flow_live[i] && flow_key[i] == k) begin
				flow_pkts[i] = flow_pkts[i] + 1'b1;
				v.flow = FLOW_W'(i + 1);
				v.pkts = flow_pkts[i];
				return v;
			end
		end
		if (flows_in_use >= FLOW_ENTRIES_DEF) begin
			v.full = 1'b1;
			return v;
		end
		flow_live[flows_in_use] = 1'b1;
		flow_key[flows_in_use]  = k;
		flow_pkts[flows_in_use] = '0;
		flows_in_use = flows_in_use + 1;
		v.flow   = FLOW_W'(flows_in_use);
		v.opened = 1'b1;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FLOW_ENTRIES_DEF; i++)
				flow_live[i] = 1'b0;
			flows_in_use = 0;
			owed_verdicts.delete();
			mismatches  = 0;
			owed        = 0;
			new_flows   = 0;
			hits        = 0;
			full_misses = 0;
		end else begin
			if (res_valid && !res_stall) begin
				seen = {flow_number, packet_number, is_new_flow, table_full};
				if (owed_verdicts.size() == 0) begin
					$error("result with no item waiting: flow_number %0d packet_number %0d",
						flow_number, packet_number);
					mismatches++;
				end else begin
					want = owed_verdicts.pop_front();
					if (seen.flow !== want.flow) begin
						$error("flow_number: expected %0d, got %0d", want.flow, seen.flow);
						mismatches++;
					end
					if (seen.pkts !== want.pkts) begin
						$error("packet_number: expected %0d, got %0d", want.pkts, seen.pkts);
						mismatches++;
					end
					if (seen.opened !== want.opened) begin
						$error("is_new_flow: expected %0b, got %0b", want.opened, seen.opened);
						mismatches++;
					end
					if (seen.full !== want.full) begin
						$error("table_full: expected %0b, got %0b", want.full, seen.full);
						mismatches++;
					end
				end
			end
			if (pkt_valid && !pkt_stall) begin
				want = classify_tuple({src_address, dst_address, src_endpoint, dst_endpoint});
				if (want.opened)
					new_flows++;
				else if (want.full)
					full_misses++;
				else
					hits++;
				owed_verdicts.push_back(want);
			end
			owed = owed_verdicts.size();
		end
	end

endmodule

/* tb/flow_tuple_classifier_core_test.sv */
// top of the flow tuple classifier test: clock, reset, packet stimulus and verdict
// depends on ftc_pkg, flow_tuple_classifier_core and flow_tuple_classifier_checker
module flow_tuple_classifier_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ftc_pkg::*;

	localparam int ITEMS        = 1600;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 12;
	localparam int FRESH_PCT    = 8;
	localparam int N_DIRECTED   = 19;
	localparam ftc_key_t DIRECTED [N_DIRECTED] = '{
		48'h0000_0000_0000, 48'h0000_0000_0000, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff,
		48'h0000_0000_0001, 48'h0000_0000_0100, 48'h0000_0001_0000, 48'h0001_0000_0000,
		48'h8000_0000_0000, 48'h0000_8000_0000, 48'h0000_0000_8000, 48'h0000_0000_0080,
		48'h0000_0000_0001, 48'h1234_5678_9abc, 48'h5678_1234_bc9a, 48'h1234_5678_9abc,
		48'h1234_5678_9abc, 48'h0000_0000_0000, 48'hffff_ffff_ffff
	};

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 pkt_valid     = 1'b0;
	logic                 pkt_stall;
	logic [ADDR_W-1:0]    src_address   = '0;
	logic [ADDR_W-1:0]    dst_address   = '0;
	logic [EP_W-1:0]      src_endpoint  = '0;
	logic [EP_W-1:0]      dst_endpoint  = '0;
	logic                 res_valid;
	logic                 res_stall     = 1'b0;
	logic [FLOW_W-1:0]    flow_number;
	logic [PKT_CNT_W-1:0] packet_number;
	logic                 is_new_flow;
	logic                 table_full;

	int       mismatches;
	int       owed;
	int       new_flows;
	int       hits;
	int       full_misses;
	int       send_idle_pct = 0;
	int       recv_idle_pct = 0;
	int       sent          = 0;
	int       cycles        = 0;
	ftc_key_t sent_tuples [$];

	flow_tuple_classifier_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.pkt_valid     (pkt_valid),
		.pkt_stall     (pkt_stall),
		.src_address   (src_address),
		.dst_address   (dst_address),
		.src_endpoint  (src_endpoint),
		.dst_endpoint  (dst_endpoint),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.flow_number   (flow_number),
		.packet_number (packet_number),
		.is_new_flow   (is_new_flow),
		.table_full    (table_full)
	);

	flow_tuple_classifier_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.pkt_valid     (pkt_valid),
		.pkt_stall     (pkt_stall),
		.src_address   (src_address),
		.dst_address   (dst_address),
		.src_endpoint  (src_endpoint),
		.dst_endpoint  (dst_endpoint),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.flow_number   (flow_number),
		.packet_number (packet_number),
		.is_new_flow   (is_new_flow),
		.table_full    (table_full),
		.mismatches    (mismatches),
		.owed          (owed),
		.new_flows     (new_flows),
		.hits          (hits),
		.full_misses   (full_misses)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_tuple(input ftc_key_t k);
		while ($urandom_range(99) < send_idle_pct) begin
			pkt_valid <= 1'b0;
			@(posedge clk);
		end
		pkt_valid <= 1'b1;
		{src_address, dst_address, src_endpoint, dst_endpoint} <= k;
		@(posedge clk);
		while (pkt_stall)
			@(posedge clk);
		sent_tuples.push_back(k);
		sent++;
	endtask

	// new tuples are either fully random or one bit away from a known one
	function automatic ftc_key_t pick_tuple();
		ftc_key_t k;
		if (sent_tuples.size() == 0 || $urandom_range(99) < FRESH_PCT) begin
			if (sent_tuples.size() == 0 || $urandom_range(1) == 0) begin
				k = ftc_key_t'({$urandom, $urandom});
			end else begin
				k = sent_tuples[$urandom_range(sent_tuples.size() - 1)];
				k = k ^ (ftc_key_t'(1) << $urandom_range(KEY_W - 1));
			end
		end else if ($urandom_range(99) < 30) begin
			k = sent_tuples[sent_tuples.size() - 1];
		end else begin
			k = sent_tuples[$urandom_range(sent_tuples.size() - 1)];
		end
		return k;
	endfunction

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_DIRECTED; i++)
			send_tuple(DIRECTED[i]);
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 29;
					recv_idle_pct = 67;
				end
				1: begin
					send_idle_pct = 67;
					recv_idle_pct = 29;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			repeat (ITEMS / 3)
				send_tuple(pick_tuple());
		end
		pkt_valid <= 1'b0;
		@(posedge clk);
		wait (owed == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d packets classified: %0d opened a flow, %0d hit a known flow,",
			sent, new_flows, hits);
		$display("%0d met a full table; idling at 29/67, 67/29 and 0/0 percent, %0d mismatches",
			full_misses, mismatches);
		if (mismatches == 0 && owed == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
